@@ rtl/fba_pkg.sv @@
// Shared constants and types of the file block allocator.
`default_nettype none
package fba_pkg;
   localparam int NUM_BLOCKS_DEF      = 128;
   localparam int NUM_ENTRIES_DEF     = 16;
   localparam int MAX_FILE_BLOCKS_DEF = 8;
   localparam int NAME_W   = 64;
   localparam int ACTION_W = 2;
   localparam int REQ_W    = 4;
   localparam int FBLK_W   = 3;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int DBLK_W   = 7;

   localparam logic [ACTION_W-1:0] ACT_CREATE    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TRANSLATE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_IGNORE    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TAKEN     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd6;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [DBLK_W-1:0]   dblk;
   } rsp_type;
endpackage
`default_nettype wire

@@ rtl/file_block_allocator.sv @@
// Top level of the file block allocator: controller, bitmap and output register.
// One transaction at a time. Each item scans the entry table through its one-read-port
// name memory; a create then walks the bitmap memory twice, a count pass and a marking
// pass that reads and then writes each visited block in turn; delete frees each block of
// the entry and translate reads one pointer. After reset a clearing pass initializes the
// bitmap (block 0 busy) and no request is accepted until it ends. The result waits in a
// register until taken.
`default_nettype none
module file_block_allocator #(
   parameter int NUM_BLOCKS      = fba_pkg::NUM_BLOCKS_DEF,
   parameter int NUM_ENTRIES     = fba_pkg::NUM_ENTRIES_DEF,
   parameter int MAX_FILE_BLOCKS = fba_pkg::MAX_FILE_BLOCKS_DEF
) (
   input  wire  logic                         clock,
   input  wire  logic                         reset,
   input  wire  logic                         req_valid,
   output logic                               req_ready,
   input  wire  logic [fba_pkg::ACTION_W-1:0] req_action,
   input  wire  logic [fba_pkg::NAME_W-1:0]   req_file_name,
   input  wire  logic [fba_pkg::REQ_W-1:0]    req_block_request,
   input  wire  logic [fba_pkg::FBLK_W-1:0]   req_file_block,
   output logic                               rsp_valid,
   input  wire  logic                         rsp_ready,
   output logic [fba_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fba_pkg::SLOT_W-1:0]         rsp_entry_slot,
   output logic [fba_pkg::DBLK_W-1:0]         rsp_disk_block
);
   localparam int BW = $clog2(NUM_BLOCKS);
   logic [BW-1:0]    rd_addr, wr_addr;
   logic             rd_busy, wr_en, wr_busy, bm_ready, res_valid;
   fba_pkg::rsp_type res_data;

   fba_bitmap #(.NUM_BLOCKS(NUM_BLOCKS)) u_bitmap (
      .clock, .reset, .rd_addr, .rd_busy, .wr_en, .wr_addr, .wr_busy,
      .clear_done(bm_ready)
   );

   fba_ctrl #(
      .NUM_BLOCKS(NUM_BLOCKS), .NUM_ENTRIES(NUM_ENTRIES),
      .MAX_FILE_BLOCKS(MAX_FILE_BLOCKS)
   ) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_file_name,
      .req_block_request, .req_file_block,
      .res_valid, .res_take(rsp_ready), .res_data,
      .bm_rd_addr(rd_addr), .bm_rd_busy(rd_busy), .bm_wr_en(wr_en),
      .bm_wr_addr(wr_addr), .bm_wr_busy(wr_busy), .bm_ready
   );

   // result is held in the controller's register while in its response state
   assign rsp_valid      = res_valid;
   assign rsp_status     = res_data.status;
   assign rsp_entry_slot = res_data.slot;
   assign rsp_disk_block = res_data.dblk;
endmodule
`default_nettype wire

@@ rtl/fba_bitmap.sv @@
// Free-block bitmap: one-bit memory with a registered read and a reset clearing sweep.
`default_nettype none
module fba_bitmap #(
   parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF,
   localparam int BW = $clog2(NUM_BLOCKS)
) (
   input  wire  logic          clock,
   input  wire  logic          reset,
   input  wire  logic [BW-1:0] rd_addr,
   output logic                rd_busy,
   input  wire  logic          wr_en,
   input  wire  logic [BW-1:0] wr_addr,
   input  wire  logic          wr_busy,
   output logic                clear_done
);
   logic mem [NUM_BLOCKS];
   logic [BW:0] clr_ff, clr_in;
   logic        rd_ff;

   assign clear_done = clr_ff[BW];
   assign rd_busy    = rd_ff;
   assign clr_in     = clear_done ? clr_ff : clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // sweep writes block 0 busy and the rest free; afterwards normal writes
   always_ff @(posedge clock) begin
      if (!clear_done) begin
         mem[clr_ff[BW-1:0]] <= (clr_ff[BW-1:0] == '0);
      end else if (wr_en) begin
         mem[wr_addr] <= wr_busy;
      end
      rd_ff <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/fba_ctrl.sv @@
// Sequencer for create, delete and translate over the entry table and the bitmap.
`default_nettype none
module fba_ctrl #(
   parameter int NUM_BLOCKS      = fba_pkg::NUM_BLOCKS_DEF,
   parameter int NUM_ENTRIES     = fba_pkg::NUM_ENTRIES_DEF,
   parameter int MAX_FILE_BLOCKS = fba_pkg::MAX_FILE_BLOCKS_DEF,
   localparam int BW = $clog2(NUM_BLOCKS),
   localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
   localparam int KW = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1,
   localparam int PW = EW + KW
) (
   input  wire  logic                            clock,
   input  wire  logic                            reset,
   input  wire  logic                            req_valid,
   output logic                                  req_ready,
   input  wire  logic [fba_pkg::ACTION_W-1:0]    req_action,
   input  wire  logic [fba_pkg::NAME_W-1:0]      req_file_name,
   input  wire  logic [fba_pkg::REQ_W-1:0]       req_block_request,
   input  wire  logic [fba_pkg::FBLK_W-1:0]      req_file_block,
   output logic                                  res_valid,
   input  wire  logic                            res_take,
   output fba_pkg::rsp_type                      res_data,
   output logic [BW-1:0]                         bm_rd_addr,
   input  wire  logic                            bm_rd_busy,
   output logic                                  bm_wr_en,
   output logic [BW-1:0]                         bm_wr_addr,
   output logic                                  bm_wr_busy,
   input  wire  logic                            bm_ready
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ESCAN = 4'd1;  // read entries one by one
   localparam logic [3:0] S_EDEC  = 4'd2;  // decide after scan
   localparam logic [3:0] S_BCNT  = 4'd3;  // count free blocks
   localparam logic [3:0] S_BALC  = 4'd4;  // mark blocks busy
   localparam logic [3:0] S_DEL   = 4'd5;  // free blocks of the entry
   localparam logic [3:0] S_TRD   = 4'd6;  // pointer read
   localparam logic [3:0] S_RSP   = 4'd7;
   localparam logic [3:0] S_DELW  = 4'd8;  // pointer read wait on delete

   localparam logic [EW:0] NE = (EW+1)'(NUM_ENTRIES);
   localparam logic [BW:0] NB = (BW+1)'(NUM_BLOCKS);

   // entry table memories; pointers are addressed as {entry, block number}
   logic [fba_pkg::NAME_W-1:0] name_mem [NUM_ENTRIES];
   logic [fba_pkg::REQ_W-1:0]  len_mem  [NUM_ENTRIES];
   logic                       vld_ff   [NUM_ENTRIES];
   logic [BW-1:0]              ptr_mem  [2**PW];

   logic [3:0]                  state_ff, state_in;
   logic [fba_pkg::ACTION_W-1:0] act_ff;
   logic [fba_pkg::NAME_W-1:0]  nm_ff;
   logic [fba_pkg::REQ_W-1:0]   rq_ff;
   logic [fba_pkg::FBLK_W-1:0]  fb_ff;
   logic [EW:0]                 ecnt_ff;
   logic                        erd_v_ff;
   logic [EW-1:0]               erd_idx_ff;
   logic [fba_pkg::NAME_W-1:0]  erd_name_ff;
   logic [fba_pkg::REQ_W-1:0]   erd_len_ff;
   logic                        erd_vld_ff;
   logic                        hit_ff, free_ok_ff;
   logic [EW-1:0]               hit_idx_ff, free_idx_ff;
   logic [fba_pkg::REQ_W-1:0]   hit_len_ff;
   logic [BW:0]                 bcnt_ff;
   logic                        brd_v_ff;
   logic [BW-1:0]               brd_idx_ff;
   logic [fba_pkg::REQ_W:0]     k_ff;
   logic [BW-1:0]               ptr_rd_ff;
   logic                        fin_ff;
   fba_pkg::rsp_type            rsp_ff;
   logic [KW-1:0]               dk;

   assign req_ready = (state_ff == S_IDLE) && bm_ready;
   assign res_valid = (state_ff == S_RSP);
   assign res_data  = rsp_ff;
   assign state_in  = state_ff;
   assign dk        = k_ff[KW-1:0];

   always_comb begin
      bm_rd_addr = bcnt_ff[BW-1:0];
      bm_wr_en   = 1'b0;
      bm_wr_addr = '0;
      bm_wr_busy = 1'b0;
      if (state_ff == S_BALC && brd_v_ff && !bm_rd_busy &&
          k_ff < {1'b0, rq_ff}) begin
         bm_wr_en   = 1'b1;
         bm_wr_addr = brd_idx_ff;
         bm_wr_busy = 1'b1;
      end else if (state_ff == S_DEL && erd_v_ff) begin
         bm_wr_en   = 1'b1;
         bm_wr_addr = ptr_rd_ff;
      end
   end

   // pointer memory: synchronous read
   always_ff @(posedge clock) begin
      ptr_rd_ff <= ptr_mem[{hit_idx_ff, dk}];
      if (state_ff == S_BALC && bm_wr_en) begin
         ptr_mem[{free_idx_ff, dk}] <= brd_idx_ff;
      end
   end

   // name and length memories: synchronous read, written on create end
   always_ff @(posedge clock) begin
      erd_name_ff <= name_mem[ecnt_ff[EW-1:0]];
      erd_len_ff  <= len_mem[ecnt_ff[EW-1:0]];
      if (fin_ff && act_ff == fba_pkg::ACT_CREATE) begin
         name_mem[free_idx_ff] <= nm_ff;
         len_mem[free_idx_ff]  <= rq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fin_ff   <= 1'b0;
         erd_v_ff <= 1'b0;
         brd_v_ff <= 1'b0;
         for (int i = 0; i < NUM_ENTRIES; i++) vld_ff[i] <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= 1'b0;
         if (fin_ff) begin
            vld_ff[act_ff == fba_pkg::ACT_CREATE ? free_idx_ff : hit_idx_ff]
               <= (act_ff == fba_pkg::ACT_CREATE);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && bm_ready) begin
                  act_ff   <= req_action;
                  nm_ff    <= req_file_name;
                  rq_ff    <= req_block_request;
                  fb_ff    <= req_file_block;
                  ecnt_ff  <= '0;
                  erd_v_ff <= 1'b0;
                  hit_ff   <= 1'b0;
                  free_ok_ff <= 1'b0;
                  hit_idx_ff <= '0;
                  free_idx_ff <= '0;
                  if (req_action != fba_pkg::ACT_IGNORE) state_ff <= S_ESCAN;
               end
            end
            S_ESCAN: begin
               // read issued at ecnt; data arrives next cycle
               erd_v_ff   <= (ecnt_ff < NE);
               erd_idx_ff <= ecnt_ff[EW-1:0];
               erd_vld_ff <= vld_ff[ecnt_ff[EW-1:0]];
               if (ecnt_ff < NE) ecnt_ff <= ecnt_ff + 1'b1;
               if (erd_v_ff) begin
                  if (erd_vld_ff && erd_name_ff == nm_ff && !hit_ff) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= erd_idx_ff;
                     hit_len_ff <= erd_len_ff;
                  end
                  if (!erd_vld_ff && !free_ok_ff) begin
                     free_ok_ff  <= 1'b1;
                     free_idx_ff <= erd_idx_ff;
                  end
               end
               if (!(ecnt_ff < NE) && !erd_v_ff) state_ff <= S_EDEC;
            end
            S_EDEC: begin
               rsp_ff   <= '{fba_pkg::ST_OK, '0, '0};
               bcnt_ff  <= '0;
               brd_v_ff <= 1'b0;
               k_ff     <= '0;
               erd_v_ff <= 1'b0;
               state_ff <= S_RSP;
               priority case (act_ff)
                  fba_pkg::ACT_CREATE: begin
                     if ({1'b0, rq_ff} > (fba_pkg::REQ_W+1)'(MAX_FILE_BLOCKS))
                        rsp_ff.status <= fba_pkg::ST_TOO_BIG;
                     else if (hit_ff)
                        rsp_ff.status <= fba_pkg::ST_TAKEN;
                     else if (!free_ok_ff)
                        rsp_ff.status <= fba_pkg::ST_FULL;
                     else
                        state_ff <= S_BCNT;
                  end
                  fba_pkg::ACT_DELETE: begin
                     if (!hit_ff) rsp_ff.status <= fba_pkg::ST_NOT_FOUND;
                     else state_ff <= S_DELW;
                  end
                  default: begin
                     if (!hit_ff) rsp_ff.status <= fba_pkg::ST_NOT_FOUND;
                     else if ({1'b0, fb_ff} >= hit_len_ff ||
                              32'(fb_ff) >= MAX_FILE_BLOCKS)
                        rsp_ff.status <= fba_pkg::ST_RANGE;
                     else begin
                        k_ff     <= (fba_pkg::REQ_W+1)'(fb_ff);
                        state_ff <= S_TRD;
                     end
                  end
               endcase
            end
            S_BCNT: begin
               // count free blocks until the request is covered or every block has been read
               brd_v_ff   <= (bcnt_ff < NB);
               brd_idx_ff <= bcnt_ff[BW-1:0];
               if (bcnt_ff < NB) bcnt_ff <= bcnt_ff + 1'b1;
               if (brd_v_ff && !bm_rd_busy) k_ff <= k_ff + 1'b1;
               if (k_ff + (brd_v_ff && !bm_rd_busy) >= {1'b0, rq_ff}) begin
                  bcnt_ff  <= '0;
                  brd_v_ff <= 1'b0;
                  k_ff     <= '0;
                  state_ff <= S_BALC;
               end else if (!(bcnt_ff < NB) && !brd_v_ff) begin
                  rsp_ff.status <= fba_pkg::ST_NO_SPACE;
                  state_ff      <= S_RSP;
               end
            end
            S_BALC: begin
               // read-modify-write: each bit is read, then written in a separate step, avoiding read-after-write
               if (k_ff >= {1'b0, rq_ff}) begin
                  fin_ff      <= 1'b1;
                  rsp_ff.slot <= fba_pkg::SLOT_W'(free_idx_ff);
                  state_ff    <= S_RSP;
               end else if (brd_v_ff) begin
                  brd_v_ff <= 1'b0;
                  if (!bm_rd_busy) k_ff <= k_ff + 1'b1;
               end else begin
                  brd_v_ff   <= 1'b1;
                  brd_idx_ff <= bcnt_ff[BW-1:0];
                  bcnt_ff    <= bcnt_ff + 1'b1;
               end
            end
            S_DELW: begin
               // pointer at k is being read
               if (k_ff >= {1'b0, hit_len_ff} ||
                   k_ff >= (fba_pkg::REQ_W+1)'(MAX_FILE_BLOCKS)) begin
                  fin_ff      <= 1'b1;
                  rsp_ff.slot <= fba_pkg::SLOT_W'(hit_idx_ff);
                  state_ff    <= S_RSP;
               end else begin
                  erd_v_ff <= 1'b1;
                  state_ff <= S_DEL;
               end
            end
            S_DEL: begin
               erd_v_ff <= 1'b0;
               k_ff     <= k_ff + 1'b1;
               state_ff <= S_DELW;
            end
            S_TRD: begin
               if (erd_v_ff) begin
                  rsp_ff.slot <= fba_pkg::SLOT_W'(hit_idx_ff);
                  rsp_ff.dblk <= fba_pkg::DBLK_W'(ptr_rd_ff);
                  state_ff    <= S_RSP;
               end
               erd_v_ff <= 1'b1;
            end
            S_RSP: begin
               if (res_take) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/fba_checker.sv @@
// Port-level checks of the file block allocator, bound to the top level.
`default_nettype none
module fba_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_status,
   input wire logic [3:0] rsp_entry_slot,
   input wire logic [6:0] rsp_disk_block
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input open while result pending");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fba_pkg::ST_OK |-> rsp_entry_slot == 4'd0 &&
      rsp_disk_block == 7'd0) else $error("error result carries data");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= fba_pkg::ST_RANGE) else $error("bad status");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped");
endmodule

bind file_block_allocator fba_checker u_fba_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_entry_slot, .rsp_disk_block
);
`default_nettype wire
